/* design/rsbe_pkg.sv */
`timescale 1ns / 1ps
package rsbe_pkg;
	localparam int REGISTER_COUNT_DEF = 256;
	localparam int STACK_DEPTH_DEF    = 256;
	localparam int HEAP_DEPTH_DEF     = 256;
	localparam int PROGRAM_DEPTH_DEF  = 256;

	localparam logic [7:0] OP_BP    = 8'h02;
	localparam logic [7:0] OP_STORE = 8'h04;
	localparam logic [7:0] OP_LOAD  = 8'h05;
	localparam logic [7:0] OP_PUSH  = 8'h06;
	localparam logic [7:0] OP_POP   = 8'h07;
	localparam logic [7:0] OP_ADD   = 8'h10;
	localparam logic [7:0] OP_SUB   = 8'h11;
	localparam logic [7:0] OP_MUL   = 8'h12;
	localparam logic [7:0] OP_DIV   = 8'h13;
	localparam logic [7:0] OP_GT    = 8'h14;
	localparam logic [7:0] OP_GE    = 8'h15;
	localparam logic [7:0] OP_EQ    = 8'h16;
	localparam logic [7:0] OP_AND   = 8'h18;
	localparam logic [7:0] OP_OR    = 8'h19;
	localparam logic [7:0] OP_NOT   = 8'h1a;
	localparam logic [7:0] OP_SHL   = 8'h1c;
	localparam logic [7:0] OP_SHR   = 8'h1d;
	localparam logic [7:0] OP_ADDI  = 8'h20;
	localparam logic [7:0] OP_SUBI  = 8'h21;
	localparam logic [7:0] OP_MULI  = 8'h22;
	localparam logic [7:0] OP_DIVI  = 8'h23;
	localparam logic [7:0] OP_GOTO  = 8'h40;
	localparam logic [7:0] OP_EXIT  = 8'h41;
	localparam logic [7:0] OP_CALL  = 8'h42;
	localparam logic [7:0] OP_RET   = 8'h43;
	localparam logic [7:0] OP_IFGT  = 8'h44;
	localparam logic [7:0] OP_IFGE  = 8'h45;
	localparam logic [7:0] OP_IFEQ  = 8'h46;
	localparam logic [7:0] OP_SET   = 8'h51;
	localparam logic [7:0] OP_GET   = 8'h52;

	localparam logic [2:0] FLT_NONE  = 3'd0;
	localparam logic [2:0] FLT_DIV0  = 3'd1;
	localparam logic [2:0] FLT_OVFL  = 3'd2;
	localparam logic [2:0] FLT_UNDF  = 3'd3;
	localparam logic [2:0] FLT_HEAP  = 3'd4;
	localparam logic [2:0] FLT_FRAME = 3'd5;

	// shared unit function codes
	localparam logic [2:0] FN_ADD = 3'd0;
	localparam logic [2:0] FN_SUB = 3'd1;
	localparam logic [2:0] FN_MUL = 3'd2;
	localparam logic [2:0] FN_DIV = 3'd3;
	localparam logic [2:0] FN_SHL = 3'd4;
	localparam logic [2:0] FN_SHR = 3'd5;

	typedef struct packed {
		logic       start;
		logic [2:0] fn;
	} alu_cmd_t;

	typedef struct packed {
		logic busy;
		logic done;
	} alu_stat_t;
endpackage

/* design/rsbe_alu.sv */
`timescale 1ns / 1ps
// Shared multi-cycle unit: add/sub in one step, multiply as 4 byte partial
// products, divide one quotient bit a cycle, shift one bit a cycle.
module rsbe_alu (
	input  logic                clk,
	input  logic                arst_n,
	input  rsbe_pkg::alu_cmd_t  cmd,
	input  logic [31:0]         x,
	input  logic [31:0]         y,
	output rsbe_pkg::alu_stat_t stat,
	output logic [31:0]         result
);
	logic [2:0]  fn_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [31:0] acc_q;
	logic [31:0] rem_q;
	logic [31:0] opy_q;
	logic [31:0] opx_q;
	logic [32:0] trial;
	logic [39:0] pp;

	assign trial = {rem_q, acc_q[31]} - {1'b0, opy_q};
	assign pp = opx_q * opy_q[7:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			fn_q   <= rsbe_pkg::FN_ADD;
		end else begin
			done_q <= 1'b0;
			if (cmd.start) begin
				fn_q   <= cmd.fn;
				opx_q  <= x;
				opy_q  <= y;
				rem_q  <= '0;
				busy_q <= 1'b1;
				unique case (cmd.fn)
					rsbe_pkg::FN_ADD: acc_q <= x + y;
					rsbe_pkg::FN_SUB: acc_q <= x - y;
					rsbe_pkg::FN_DIV: acc_q <= x;
					rsbe_pkg::FN_MUL: acc_q <= '0;
					default:          acc_q <= (y > 32'd31) ? 32'd0 : x;
				endcase
				unique case (cmd.fn)
					rsbe_pkg::FN_ADD, rsbe_pkg::FN_SUB: cnt_q <= 6'd0;
					rsbe_pkg::FN_MUL: cnt_q <= 6'd4;
					rsbe_pkg::FN_DIV: cnt_q <= 6'd32;
					default: cnt_q <= (y > 32'd31) ? 6'd0 : y[5:0];
				endcase
			end else if (busy_q) begin
				if (cnt_q == 6'd0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 6'd1;
					unique case (fn_q)
						rsbe_pkg::FN_MUL: begin
							acc_q <= acc_q + pp[31:0];
							opx_q <= {opx_q[23:0], 8'd0};
							opy_q <= {8'd0, opy_q[31:8]};
						end
						rsbe_pkg::FN_DIV: begin
							if (!trial[32]) begin
								rem_q <= trial[31:0];
								acc_q <= {acc_q[30:0], 1'b1};
							end else begin
								rem_q <= {rem_q[30:0], acc_q[31]};
								acc_q <= {acc_q[30:0], 1'b0};
							end
						end
						rsbe_pkg::FN_SHL: acc_q <= {acc_q[30:0], 1'b0};
						rsbe_pkg::FN_SHR: acc_q <= {1'b0, acc_q[31:1]};
						default: acc_q <= acc_q;
					endcase
				end
			end
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign result = acc_q;
endmodule

/* design/register_stack_bytecode_executor.sv */
`timescale 1ns / 1ps
// channel  dir  beat fields                     handshake
// in       in   mode, op_a, op_b, op_c          in_valid / in_stall
// out      out  next_pc, exited, breakpoint,    out_valid / out_stall
//               fault, written_value
// cfg      in   start address at 0x0            APB
// Fetch and execute pass RDB, RDC, RDA, RDW and EXEC; then arithmetic waits on the shared unit,
// compares, branches and the rest pass DONE, LOAD/POP/GET pass MEMRD and MEMWB, RET RET1 and RET2,
// CALL passes ZERO, which zeroes the locals, and CRET; STORE/PUSH/SET and faults finish in EXEC.
// Register file has one read and one write port, stack and heap one port; reads registered.
// Reset puts pc at the reset start address and stack and frame pointers at 0.
// in_stall is high while an instruction is in flight or a result beat waits.
module register_stack_bytecode_executor #(
	parameter int REGISTER_COUNT = rsbe_pkg::REGISTER_COUNT_DEF,
	parameter int STACK_DEPTH    = rsbe_pkg::STACK_DEPTH_DEF,
	parameter int HEAP_DEPTH     = rsbe_pkg::HEAP_DEPTH_DEF,
	parameter int PROGRAM_DEPTH  = rsbe_pkg::PROGRAM_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  mode,
	input  logic [7:0]  op_a,
	input  logic [7:0]  op_b,
	input  logic [7:0]  op_c,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  next_pc,
	output logic        exited,
	output logic        breakpoint,
	output logic [2:0]  fault,
	output logic [31:0] written_value,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [1:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	localparam int RW = $clog2(REGISTER_COUNT);
	localparam int SW = $clog2(STACK_DEPTH);
	localparam int HW = $clog2(HEAP_DEPTH);
	localparam int PW = $clog2(PROGRAM_DEPTH);
	localparam int TW = SW + 1;

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_RDB   = 4'd1;
	localparam logic [3:0] ST_RDC   = 4'd2;
	localparam logic [3:0] ST_RDA   = 4'd3;
	localparam logic [3:0] ST_EXEC  = 4'd4;
	localparam logic [3:0] ST_ALU   = 4'd5;
	localparam logic [3:0] ST_MEMRD = 4'd6;
	localparam logic [3:0] ST_MEMWB = 4'd7;
	localparam logic [3:0] ST_ZERO  = 4'd8;
	localparam logic [3:0] ST_CRET  = 4'd9;
	localparam logic [3:0] ST_RET1  = 4'd10;
	localparam logic [3:0] ST_RET2  = 4'd11;
	localparam logic [3:0] ST_DONE  = 4'd12;
	localparam logic [3:0] ST_RDW   = 4'd13;

	logic [3:0]  state_q;
	logic [7:0]  entry_q;
	logic [PW-1:0] pc_q;
	logic [TW-1:0] sp_q;
	logic [TW-1:0] fb_q;
	logic [7:0]  op_q, a_q, b_q, c_q;
	logic [31:0] x_q, y_q, z_q;
	logic [7:0]  cnt_q;
	logic        ovalid_q;
	logic [7:0]  npc_q;
	logic        ex_q, bp_q;
	logic [2:0]  flt_q;
	logic [31:0] wv_q;
	logic [31:0] fbsave_q;

	logic [31:0] rf_mem [REGISTER_COUNT];
	logic [31:0] st_mem [STACK_DEPTH];
	logic [31:0] hp_mem [HEAP_DEPTH];
	logic [31:0] rf_rd_q, st_rd_q, hp_rd_q;

	logic          rf_we;
	logic [RW-1:0] rf_wa, rf_ra;
	logic [31:0]   rf_wd;
	logic          st_we;
	logic [SW-1:0] st_addr;
	logic [31:0]   st_wd;
	logic          hp_we;
	logic [HW-1:0] hp_addr;
	logic [31:0]   hp_wd;

	rsbe_pkg::alu_cmd_t  acmd;
	rsbe_pkg::alu_stat_t astat;
	logic [31:0] ares;

	rsbe_alu u_alu (
		.clk(clk), .arst_n(arst_n), .cmd(acmd), .x(x_q), .y(y_q),
		.stat(astat), .result(ares)
	);

	logic in_acc;
	assign in_acc = in_valid && !in_stall;
	assign in_stall = (state_q != ST_IDLE) || ovalid_q;
	assign pready = 1'b1;
	assign prdata = {24'd0, entry_q};

	always_ff @(posedge clk) begin
		if (rf_we) rf_mem[rf_wa] <= rf_wd;
		rf_rd_q <= rf_mem[rf_ra];
	end
	always_ff @(posedge clk) begin
		if (st_we) st_mem[st_addr] <= st_wd;
		st_rd_q <= st_mem[st_addr];
	end
	always_ff @(posedge clk) begin
		if (hp_we) hp_mem[hp_addr] <= hp_wd;
		hp_rd_q <= hp_mem[hp_addr];
	end

	// derived addresses and checks
	logic [TW:0]     frame_addr;
	logic [32:0]     heap_addr;
	logic [TW+8:0]   call_need;
	logic [PW-1:0]   pc_inc, rel_pc;
	logic [7:0]      pc8;
	logic            is_alu, is_imm, is_div, is_cmp;
	logic [31:0]     cmp_r;
	logic            br_take;

	assign frame_addr = (TW+1)'(fb_q) + (TW+1)'(a_q);
	assign heap_addr = {1'b0, x_q} + 33'(b_q);
	assign call_need = (TW+9)'(sp_q) + (TW+9)'(2) + (TW+9)'(a_q);
	assign pc_inc = pc_q + PW'(1);
	assign rel_pc = pc_q + PW'({{8{a_q[7]}}, a_q});
	assign pc8 = 8'(pc_inc);

	always_comb begin
		is_imm = 1'b0;
		is_alu = 1'b0;
		case (op_q) inside
			rsbe_pkg::OP_ADD, rsbe_pkg::OP_SUB, rsbe_pkg::OP_MUL, rsbe_pkg::OP_DIV,
			rsbe_pkg::OP_SHL, rsbe_pkg::OP_SHR: is_alu = 1'b1;
			rsbe_pkg::OP_ADDI, rsbe_pkg::OP_SUBI, rsbe_pkg::OP_MULI,
			rsbe_pkg::OP_DIVI: begin
				is_alu = 1'b1;
				is_imm = 1'b1;
			end
			default: ;
		endcase
	end
	assign is_div = (op_q == rsbe_pkg::OP_DIV) || (op_q == rsbe_pkg::OP_DIVI);
	always_comb begin
		is_cmp = 1'b1;
		cmp_r = '0;
		case (op_q)
			rsbe_pkg::OP_GT:  cmp_r = {31'd0, x_q > y_q};
			rsbe_pkg::OP_GE:  cmp_r = {31'd0, x_q >= y_q};
			rsbe_pkg::OP_EQ:  cmp_r = {31'd0, x_q == y_q};
			rsbe_pkg::OP_AND: cmp_r = {31'd0, (x_q != 0) && (y_q != 0)};
			rsbe_pkg::OP_OR:  cmp_r = {31'd0, (x_q != 0) || (y_q != 0)};
			rsbe_pkg::OP_NOT: cmp_r = {31'd0, x_q == 0};
			default: is_cmp = 1'b0;
		endcase
	end
	assign br_take = (op_q == rsbe_pkg::OP_IFGT && x_q > y_q) ||
		(op_q == rsbe_pkg::OP_IFGE && x_q >= y_q) ||
		(op_q == rsbe_pkg::OP_IFEQ && x_q == y_q);

	logic [2:0] alu_fn;
	always_comb begin
		case (op_q)
			rsbe_pkg::OP_ADD, rsbe_pkg::OP_ADDI: alu_fn = rsbe_pkg::FN_ADD;
			rsbe_pkg::OP_SUB, rsbe_pkg::OP_SUBI: alu_fn = rsbe_pkg::FN_SUB;
			rsbe_pkg::OP_MUL, rsbe_pkg::OP_MULI: alu_fn = rsbe_pkg::FN_MUL;
			rsbe_pkg::OP_SHL: alu_fn = rsbe_pkg::FN_SHL;
			rsbe_pkg::OP_SHR: alu_fn = rsbe_pkg::FN_SHR;
			default: alu_fn = rsbe_pkg::FN_DIV;
		endcase
	end

	// memory port control
	always_comb begin
		rf_we = 1'b0; rf_wa = RW'(a_q); rf_wd = z_q; rf_ra = RW'(b_q);
		st_we = 1'b0; st_addr = SW'(sp_q); st_wd = z_q;
		hp_we = 1'b0; hp_addr = HW'(heap_addr); hp_wd = y_q;
		acmd.start = 1'b0; acmd.fn = alu_fn;
		unique case (state_q)
			ST_IDLE:  rf_ra = RW'(op_b);
			ST_RDB:   rf_ra = RW'(c_q);
			ST_RDC:   rf_ra = RW'(a_q);
			ST_EXEC: begin
				acmd.start = is_alu && !(is_div && y_q == 0);
				unique case (op_q)
					rsbe_pkg::OP_STORE: begin
						st_addr = SW'(frame_addr);
						st_wd = x_q;
						st_we = (frame_addr < (TW+1)'(STACK_DEPTH));
					end
					rsbe_pkg::OP_LOAD: st_addr = SW'(frame_addr);
					rsbe_pkg::OP_PUSH: begin
						st_wd = z_q;
						st_we = (sp_q < TW'(STACK_DEPTH));
					end
					rsbe_pkg::OP_POP: st_addr = SW'(sp_q - TW'(1));
					rsbe_pkg::OP_CALL: begin
						st_wd = 32'(fb_q);
						st_we = (call_need <= (TW+9)'(STACK_DEPTH));
					end
					rsbe_pkg::OP_RET: st_addr = SW'(sp_q - TW'(1));
					rsbe_pkg::OP_SET: hp_we = (heap_addr < 33'(HEAP_DEPTH));
					default: ;
				endcase
			end
			ST_RET1: st_addr = SW'(fb_q - TW'(1));
			ST_ZERO: begin
				st_wd = '0;
				st_we = (cnt_q != 0);
			end
			ST_CRET: begin
				st_wd = 32'(pc8);
				st_we = 1'b1;
			end
			ST_MEMWB: begin
				rf_we = 1'b1;
				rf_wa = (op_q == rsbe_pkg::OP_GET) ? RW'(c_q) :
					(op_q == rsbe_pkg::OP_LOAD) ? RW'(b_q) : RW'(a_q);
				rf_wd = z_q;
			end
			ST_ALU: begin
				rf_we = astat.done;
				rf_wd = ares;
			end
			ST_DONE: begin
				rf_we = is_cmp;
				rf_wd = cmp_r;
			end
			default: ;
		endcase
	end

	task automatic finish(input logic [7:0] np, input logic [2:0] f,
		input logic [31:0] wv);
		npc_q <= np;
		flt_q <= f;
		wv_q <= wv;
		ovalid_q <= 1'b1;
		state_q <= ST_IDLE;
	endtask

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			entry_q <= 8'd0;
			pc_q <= '0;
			sp_q <= '0;
			fb_q <= '0;
			ovalid_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (psel && penable && pwrite && paddr == 2'd0)
				entry_q <= pwdata[7:0];
			if (ovalid_q && !out_stall)
				ovalid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: if (in_acc) begin
					op_q <= mode; a_q <= op_a; b_q <= op_b; c_q <= op_c;
					ex_q <= 1'b0; bp_q <= 1'b0;
					state_q <= ST_RDB;
				end
				// read data lands in the cycle after its address: r[b], then r[c], then r[a]
				ST_RDB: begin
					x_q <= rf_rd_q;
					state_q <= ST_RDC;
				end
				ST_RDC: begin
					y_q <= is_imm ? 32'(c_q) : rf_rd_q;
					state_q <= ST_RDA;
				end
				ST_RDA: begin
					z_q <= rf_rd_q;
					state_q <= ST_RDW;
				end
				ST_RDW: begin
					// heap address base is r[a]
					if (op_q == rsbe_pkg::OP_SET || op_q == rsbe_pkg::OP_GET)
						x_q <= z_q;
					state_q <= ST_EXEC;
				end
				ST_EXEC: begin
					if (is_alu) begin
						if (is_div && y_q == 0) begin
							pc_q <= pc_inc;
							finish(pc8, rsbe_pkg::FLT_DIV0, 32'd0);
						end else state_q <= ST_ALU;
					end else unique case (op_q)
						rsbe_pkg::OP_STORE, rsbe_pkg::OP_LOAD: begin
							if (frame_addr >= (TW+1)'(STACK_DEPTH)) begin
								pc_q <= pc_inc;
								finish(pc8, rsbe_pkg::FLT_FRAME, 32'd0);
							end else if (op_q == rsbe_pkg::OP_STORE) begin
								pc_q <= pc_inc;
								finish(pc8, rsbe_pkg::FLT_NONE, x_q);
							end else state_q <= ST_MEMRD;
						end
						rsbe_pkg::OP_PUSH: begin
							pc_q <= pc_inc;
							if (sp_q >= TW'(STACK_DEPTH))
								finish(pc8, rsbe_pkg::FLT_OVFL, 32'd0);
							else begin
								sp_q <= sp_q + TW'(1);
								finish(pc8, rsbe_pkg::FLT_NONE, z_q);
							end
						end
						rsbe_pkg::OP_POP: begin
							if (sp_q == 0) begin
								pc_q <= pc_inc;
								finish(pc8, rsbe_pkg::FLT_UNDF, 32'd0);
							end else begin
								sp_q <= sp_q - TW'(1);
								state_q <= ST_MEMRD;
							end
						end
						rsbe_pkg::OP_SET, rsbe_pkg::OP_GET: begin
							if (heap_addr >= 33'(HEAP_DEPTH)) begin
								pc_q <= pc_inc;
								finish(pc8, rsbe_pkg::FLT_HEAP, 32'd0);
							end else if (op_q == rsbe_pkg::OP_SET) begin
								pc_q <= pc_inc;
								finish(pc8, rsbe_pkg::FLT_NONE, y_q);
							end else state_q <= ST_MEMRD;
						end
						rsbe_pkg::OP_CALL: begin
							if (call_need > (TW+9)'(STACK_DEPTH)) begin
								pc_q <= pc_inc;
								finish(pc8, rsbe_pkg::FLT_OVFL, 32'd0);
							end else begin
								sp_q <= sp_q + TW'(1);
								fb_q <= sp_q + TW'(1);
								cnt_q <= a_q;
								state_q <= ST_ZERO;
							end
						end
						rsbe_pkg::OP_RET: begin
							if (sp_q == 0 || fb_q == 0) begin
								pc_q <= pc_inc;
								finish(pc8, rsbe_pkg::FLT_UNDF, 32'd0);
							end else state_q <= ST_RET1;
						end
						default: state_q <= ST_DONE;
					endcase
				end
				ST_ALU: if (astat.done) begin
					pc_q <= pc_inc;
					finish(pc8, rsbe_pkg::FLT_NONE, ares);
				end
				ST_MEMRD: begin
					z_q <= (op_q == rsbe_pkg::OP_GET) ? hp_rd_q : st_rd_q;
					state_q <= ST_MEMWB;
				end
				ST_MEMWB: begin
					pc_q <= pc_inc;
					finish(pc8, rsbe_pkg::FLT_NONE, z_q);
				end
				ST_ZERO: begin
					if (cnt_q == 0) state_q <= ST_CRET;
					else begin
						cnt_q <= cnt_q - 8'd1;
						sp_q <= sp_q + TW'(1);
					end
				end
				ST_CRET: begin
					sp_q <= sp_q + TW'(1);
					pc_q <= PW'(c_q);
					finish(8'(PW'(c_q)), rsbe_pkg::FLT_NONE, 32'(pc8));
				end
				ST_RET1: begin
					fbsave_q <= st_rd_q; // return address
					state_q <= ST_RET2;
				end
				ST_RET2: begin
					sp_q <= fb_q - TW'(1);
					fb_q <= (st_rd_q > 32'(STACK_DEPTH)) ? TW'(STACK_DEPTH) :
						TW'(st_rd_q);
					pc_q <= PW'(fbsave_q);
					finish(8'(PW'(fbsave_q)), rsbe_pkg::FLT_NONE, 32'd0);
				end
				ST_DONE: begin
					if (op_q == rsbe_pkg::OP_EXIT) begin
						ex_q <= 1'b1;
						pc_q <= PW'(entry_q);
						finish(8'(PW'(entry_q)), rsbe_pkg::FLT_NONE, 32'd0);
					end else if (op_q == rsbe_pkg::OP_GOTO || br_take) begin
						pc_q <= rel_pc;
						finish(8'(rel_pc), rsbe_pkg::FLT_NONE, 32'd0);
					end else begin
						bp_q <= (op_q == rsbe_pkg::OP_BP);
						pc_q <= pc_inc;
						finish(pc8, rsbe_pkg::FLT_NONE, is_cmp ? cmp_r : 32'd0);
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid = ovalid_q;
	assign next_pc = npc_q;
	assign exited = ex_q;
	assign breakpoint = bp_q;
	assign fault = flt_q;
	assign written_value = wv_q;

	a_busy_no_in: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> in_stall)
		else $error("input taken while busy");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(written_value)))
		else $error("result dropped");
	a_sp_range: assert property (@(posedge clk) disable iff (!arst_n)
		sp_q <= TW'(STACK_DEPTH))
		else $error("stack pointer out of range");
endmodule
